// ===== hw/rtl/cdg_pkg.sv =====
`default_nettype none

package cdg_pkg;

  // Default configuration
  localparam int unsigned DEF_NUM_DENOMS = 9;
  localparam int unsigned DEF_COUNT_BITS = 32;

  // Fixed widths of the item fields
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned DVAL_W    = 16;
  localparam int unsigned QTY_W     = 32;
  localparam int unsigned AMOUNT_W  = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned VALUE_W   = 13;
  localparam int unsigned OCOUNT_W  = 32;

  // Denomination table: nine real slots, up to sixteen addressable
  localparam int unsigned TABLE_DENOMS = 9;
  localparam int unsigned SLOT_W       = 4;
  localparam int unsigned RECIP_W      = 29;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PROVISION = 2'd0,
    ACT_INSERT    = 2'd1,
    ACT_DISPENSE  = 2'd2,
    ACT_ROLLBACK  = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DENOM = 2'd1,
    ST_NO_CASH   = 2'd2
  } status_e;

  typedef struct packed {
    action_e             action;
    logic [DVAL_W-1:0]   denom_value;
    logic [QTY_W-1:0]    quantity;
    logic [AMOUNT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [VALUE_W-1:0]  out_value;
    logic [OCOUNT_W-1:0] out_count;
    logic                last;
  } out_item_t;

  // Denomination value in cents of a slot, zero for an unused slot
  function automatic logic [VALUE_W-1:0] slot_value(input logic [SLOT_W-1:0] slot);
    logic [VALUE_W-1:0] v;
    case (slot)
      4'd0:    v = 13'd10;
      4'd1:    v = 13'd20;
      4'd2:    v = 13'd50;
      4'd3:    v = 13'd100;
      4'd4:    v = 13'd200;
      4'd5:    v = 13'd500;
      4'd6:    v = 13'd1000;
      4'd7:    v = 13'd2000;
      4'd8:    v = 13'd5000;
      default: v = '0;
    endcase
    return v;
  endfunction

  // floor(2^32 / value): quotient estimate is low by at most one
  function automatic logic [RECIP_W-1:0] slot_recip(input logic [SLOT_W-1:0] slot);
    logic [RECIP_W-1:0] m;
    case (slot)
      4'd0:    m = 29'd429496729;
      4'd1:    m = 29'd214748364;
      4'd2:    m = 29'd85899345;
      4'd3:    m = 29'd42949672;
      4'd4:    m = 29'd21474836;
      4'd5:    m = 29'd8589934;
      4'd6:    m = 29'd4294967;
      4'd7:    m = 29'd2147483;
      4'd8:    m = 29'd858993;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cdg_cnt_mem.sv =====
`default_nettype none

module cdg_cnt_mem #(
  parameter int unsigned DEPTH = cdg_pkg::DEF_NUM_DENOMS,
  parameter int unsigned WIDTH = cdg_pkg::DEF_COUNT_BITS,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic             rd_en_i,
  input  wire logic             wr_en_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [DEPTH-1:0] vld_q;
  logic             rd_vld_q;

  // Write and read the count array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[addr_i];
    end
  end

  // Track written entries; an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/cdg_quot.sv =====
`default_nettype none

module cdg_quot (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [cdg_pkg::AMOUNT_W-1:0]   rem_i,
  input  wire logic [cdg_pkg::SLOT_W-1:0]     slot_i,
  output logic                                done_o,
  output logic      [cdg_pkg::AMOUNT_W-1:0]   quot_o
);

  import cdg_pkg::*;

  localparam int unsigned PROD_W = 2 * AMOUNT_W;
  localparam int unsigned QV_W   = AMOUNT_W + VALUE_W;

  logic [AMOUNT_W-1:0] rem_q;
  logic [VALUE_W-1:0]  val_q;
  logic [RECIP_W-1:0]  m_q;
  logic [PROD_W-1:0]   prod_q;
  logic [AMOUNT_W-1:0] qe;
  logic [AMOUNT_W-1:0] qe_q;
  logic [QV_W-1:0]     qv_q;
  logic [AMOUNT_W-1:0] rest;
  logic [AMOUNT_W-1:0] quot_q;
  logic [3:0]          stg_q;

  assign qe   = prod_q[PROD_W-1:AMOUNT_W];
  assign rest = rem_q - qv_q[AMOUNT_W-1:0];

  // Latch operands, then multiply by the reciprocal, back-multiply, correct
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      val_q <= slot_value(slot_i);
      m_q   <= slot_recip(slot_i);
    end
    prod_q <= PROD_W'(rem_q) * PROD_W'(m_q);
    qe_q   <= qe;
    qv_q   <= QV_W'(qe) * QV_W'(val_q);
    quot_q <= qe_q + AMOUNT_W'((val_q != '0) && (rest >= AMOUNT_W'(val_q)));
  end

  // Advance the stage marker alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= '0;
    end else begin
      stg_q <= {stg_q[2:0], start_i};
    end
  end

  assign done_o = stg_q[3];
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== hw/rtl/change_dispenser_greedy_unit.sv =====
// Change dispenser with per-denomination stock and escrow counts.
// Input channel (in_valid_i / in_stall_o / in_item_i) takes one command item:
// provision, insert, dispense or rollback. Output channel (out_valid_o /
// out_stall_i / out_item_o) returns one or more result items per command;
// the final item of a command has last set.
// Commands are processed one at a time. Provision and insert go through
// read, update and emit (a bad denomination skips the update). Dispense
// walks the slots from the largest value down (read, add, wait on the
// reciprocal multiplier chain of the quotient unit, pay), then, if the
// amount is covered, commits slot by slot (read, write). Rollback reads and
// clears each escrow count in turn. Every count read goes through a
// synchronous count memory.
// Reset clears all stock and escrow counts at once; the block leaves reset
// idle and ready to accept an item. A result waits in the output register
// while the receiver stalls; the walk pauses before emitting the next one.
`default_nettype none

module change_dispenser_greedy_unit #(
  parameter int unsigned NUM_DENOMS = cdg_pkg::DEF_NUM_DENOMS,
  parameter int unsigned COUNT_BITS = cdg_pkg::DEF_COUNT_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire cdg_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output cdg_pkg::out_item_t      out_item_o
);

  import cdg_pkg::*;

  localparam int unsigned IDX_W     = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;
  localparam int unsigned SUM_W     = QTY_W + 1;
  localparam int unsigned NUM_REAL  =
      (NUM_DENOMS < TABLE_DENOMS) ? NUM_DENOMS : TABLE_DENOMS;
  localparam int unsigned LAST_REAL = NUM_REAL - 1;
  localparam int unsigned LAST_SLOT = NUM_DENOMS - 1;
  localparam int unsigned PAY_W     = AMOUNT_W + VALUE_W;
  localparam logic [SUM_W-1:0] CNT_MAX = SUM_W'((64'd1 << COUNT_BITS) - 64'd1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD,
    S_SINGLE,
    S_D_RD,
    S_D_AV,
    S_D_WAIT,
    S_D_PAY,
    S_D_CHK,
    S_C_RD,
    S_C_WR,
    S_R_RD,
    S_R_WR
  } state_e;

  function automatic logic [COUNT_BITS-1:0] sat_cnt(input logic [SUM_W-1:0] v);
    return (v > CNT_MAX) ? COUNT_BITS'(CNT_MAX) : COUNT_BITS'(v);
  endfunction

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    i_q, i_d;
  action_e             act_q, act_d;
  logic [QTY_W-1:0]    qty_q, qty_d;
  logic [AMOUNT_W-1:0] rem_q, rem_d;
  logic [VALUE_W-1:0]  val_q, val_d;
  logic [SUM_W-1:0]    avail_q, avail_d;
  logic [AMOUNT_W-1:0] unit_q, unit_d;
  logic                any_q, any_d;
  status_e             res_status_q, res_status_d;
  logic [VALUE_W-1:0]  res_value_q, res_value_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_item_q, out_item_d;

  logic [AMOUNT_W-1:0] paid_q [NUM_DENOMS];
  logic                paid_we;

  logic                slot_hit;
  logic [IDX_W-1:0]    slot;
  logic                later_nz;
  logic                out_free;
  logic                push;
  out_item_t           push_item;

  logic [IDX_W-1:0]      mem_addr;
  logic                  st_rd_en, st_wr_en, pd_rd_en, pd_wr_en;
  logic [COUNT_BITS-1:0] st_wr_data, pd_wr_data, st_rd_data, pd_rd_data;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [AMOUNT_W-1:0]   cur_paid;
  logic [PAY_W-1:0]      pay;

  logic                div_start, div_done;
  logic [AMOUNT_W-1:0] div_quot;

  cdg_cnt_mem #(
    .DEPTH (NUM_DENOMS),
    .WIDTH (COUNT_BITS),
    .AW    (IDX_W)
  ) u_stock_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .addr_i    (mem_addr),
    .rd_en_i   (st_rd_en),
    .wr_en_i   (st_wr_en),
    .wr_data_i (st_wr_data),
    .rd_data_o (st_rd_data)
  );

  cdg_cnt_mem #(
    .DEPTH (NUM_DENOMS),
    .WIDTH (COUNT_BITS),
    .AW    (IDX_W)
  ) u_pend_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .addr_i    (mem_addr),
    .rd_en_i   (pd_rd_en),
    .wr_en_i   (pd_wr_en),
    .wr_data_i (pd_wr_data),
    .rd_data_o (pd_rd_data)
  );

  cdg_quot u_quot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (rem_q),
    .slot_i  (SLOT_W'(i_q)),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Match the incoming denomination against the slot table
  always_comb begin
    slot_hit = 1'b0;
    slot     = '0;
    for (int j = 0; j < NUM_DENOMS; j++) begin
      if (!slot_hit && (in_item_i.denom_value != '0) &&
          (DVAL_W'(slot_value(SLOT_W'(j))) == in_item_i.denom_value)) begin
        slot_hit = 1'b1;
        slot     = IDX_W'(j);
      end
    end
  end

  // Flag any paid slot above the current one
  always_comb begin
    later_nz = 1'b0;
    for (int j = 0; j < NUM_DENOMS; j++) begin
      if ((IDX_W'(j) > i_q) && (paid_q[j] != '0)) begin
        later_nz = 1'b1;
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign mem_addr = (state_q == S_IDLE) ? slot : i_q;
  assign cur_cnt  = (act_q == ACT_PROVISION) ? st_rd_data : pd_rd_data;
  assign cur_paid = paid_q[i_q];
  assign pay      = PAY_W'(unit_q) * PAY_W'(val_q);

  // Sequence the commands over the count memories
  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    act_d        = act_q;
    qty_d        = qty_q;
    rem_d        = rem_q;
    val_d        = val_q;
    avail_d      = avail_q;
    unit_d       = unit_q;
    any_d        = any_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    st_rd_en     = 1'b0;
    pd_rd_en     = 1'b0;
    st_wr_en     = 1'b0;
    pd_wr_en     = 1'b0;
    st_wr_data   = '0;
    pd_wr_data   = '0;
    div_start    = 1'b0;
    paid_we      = 1'b0;
    push         = 1'b0;
    push_item    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d = in_item_i.action;
          qty_d = in_item_i.quantity;
          unique case (in_item_i.action) inside
            ACT_PROVISION, ACT_INSERT: begin
              if (slot_hit) begin
                i_d          = slot;
                st_rd_en     = (in_item_i.action == ACT_PROVISION);
                pd_rd_en     = (in_item_i.action == ACT_INSERT);
                res_status_d = ST_OK;
                res_value_d  = in_item_i.denom_value[VALUE_W-1:0];
                state_d      = S_UPD;
              end else begin
                res_status_d = ST_BAD_DENOM;
                res_value_d  = '0;
                state_d      = S_SINGLE;
              end
            end
            ACT_DISPENSE: begin
              rem_d   = in_item_i.amount;
              i_d     = IDX_W'(LAST_SLOT);
              any_d   = 1'b0;
              state_d = S_D_RD;
            end
            ACT_ROLLBACK: begin
              i_d     = '0;
              state_d = S_R_RD;
            end
          endcase
        end
      end

      // Add the quantity to the addressed count, saturating
      S_UPD: begin
        st_wr_en   = (act_q == ACT_PROVISION);
        pd_wr_en   = (act_q == ACT_INSERT);
        st_wr_data = sat_cnt(SUM_W'(cur_cnt) + SUM_W'(qty_q));
        pd_wr_data = sat_cnt(SUM_W'(cur_cnt) + SUM_W'(qty_q));
        state_d    = S_SINGLE;
      end

      S_SINGLE: begin
        if (out_free) begin
          push                = 1'b1;
          push_item.status    = res_status_q;
          push_item.out_value = res_value_q;
          push_item.out_count = '0;
          push_item.last      = 1'b1;
          state_d             = S_IDLE;
        end
      end

      // Greedy walk: read counts and start the quotient
      S_D_RD: begin
        st_rd_en  = 1'b1;
        pd_rd_en  = 1'b1;
        div_start = 1'b1;
        val_d     = slot_value(SLOT_W'(i_q));
        state_d   = S_D_AV;
      end

      S_D_AV: begin
        avail_d = SUM_W'(st_rd_data) + SUM_W'(pd_rd_data);
        state_d = S_D_WAIT;
      end

      // Take the smaller of quotient and available units
      S_D_WAIT: begin
        if (div_done) begin
          if (val_q == '0) begin
            unit_d = '0;
          end else if (SUM_W'(div_quot) < avail_q) begin
            unit_d = div_quot;
          end else begin
            unit_d = AMOUNT_W'(avail_q);
          end
          paid_we = 1'b1;
          if (unit_d != '0) begin
            any_d = 1'b1;
          end
          state_d = S_D_PAY;
        end
      end

      S_D_PAY: begin
        rem_d = rem_q - pay[AMOUNT_W-1:0];
        if (i_q == '0) begin
          state_d = S_D_CHK;
        end else begin
          i_d     = i_q - IDX_W'(1);
          state_d = S_D_RD;
        end
      end

      S_D_CHK: begin
        if (rem_q != '0) begin
          res_status_d = ST_NO_CASH;
          res_value_d  = '0;
          state_d      = S_SINGLE;
        end else begin
          i_d     = '0;
          state_d = S_C_RD;
        end
      end

      // Commit: move escrow into stock, drop paid units, emit used slots
      S_C_RD: begin
        st_rd_en = 1'b1;
        pd_rd_en = 1'b1;
        state_d  = S_C_WR;
      end

      S_C_WR: begin
        if ((cur_paid == '0) || out_free) begin
          st_wr_en   = 1'b1;
          pd_wr_en   = 1'b1;
          st_wr_data = sat_cnt(SUM_W'(st_rd_data) + SUM_W'(pd_rd_data) - SUM_W'(cur_paid));
          pd_wr_data = '0;
          if (cur_paid != '0) begin
            push                = 1'b1;
            push_item.status    = ST_OK;
            push_item.out_value = slot_value(SLOT_W'(i_q));
            push_item.out_count = cur_paid;
            push_item.last      = !later_nz;
          end
          if (i_q == IDX_W'(LAST_SLOT)) begin
            if (any_q) begin
              state_d = S_IDLE;
            end else begin
              res_status_d = ST_OK;
              res_value_d  = '0;
              state_d      = S_SINGLE;
            end
          end else begin
            i_d     = i_q + IDX_W'(1);
            state_d = S_C_RD;
          end
        end
      end

      // Rollback: return and clear each escrow count
      S_R_RD: begin
        pd_rd_en = 1'b1;
        state_d  = S_R_WR;
      end

      S_R_WR: begin
        if (out_free) begin
          pd_wr_en            = 1'b1;
          pd_wr_data          = '0;
          push                = 1'b1;
          push_item.status    = ST_OK;
          push_item.out_value = slot_value(SLOT_W'(i_q));
          push_item.out_count = OCOUNT_W'(pd_rd_data);
          push_item.last      = (i_q == IDX_W'(LAST_REAL));
          if (i_q == IDX_W'(LAST_REAL)) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + IDX_W'(1);
            state_d = S_R_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Load the output register on a push, drop valid once taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_item_d  = push_item;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      i_q          <= '0;
      act_q        <= ACT_PROVISION;
      qty_q        <= '0;
      rem_q        <= '0;
      val_q        <= '0;
      avail_q      <= '0;
      unit_q       <= '0;
      any_q        <= 1'b0;
      res_status_q <= ST_OK;
      res_value_q  <= '0;
      out_valid_q  <= 1'b0;
      out_item_q   <= '0;
    end else begin
      state_q      <= state_d;
      i_q          <= i_d;
      act_q        <= act_d;
      qty_q        <= qty_d;
      rem_q        <= rem_d;
      val_q        <= val_d;
      avail_q      <= avail_d;
      unit_q       <= unit_d;
      any_q        <= any_d;
      res_status_q <= res_status_d;
      res_value_q  <= res_value_d;
      out_valid_q  <= out_valid_d;
      out_item_q   <= out_item_d;
    end
  end

  // Record units paid per slot during the walk
  always_ff @(posedge clk_i) begin
    if (paid_we) begin
      paid_q[i_q] <= unit_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import cdg_pkg::*;

  // Cash model: stock and escrow per coin slot, expected result items in order
  class cash_scoreboard;
    logic [31:0] stock [9];
    logic [31:0] escrow [9];
    out_item_t   due_results [$];
    int unsigned err_cnt = 0;

    function new();
      for (int i = 0; i < 9; i++) begin
        stock[i]  = '0;
        escrow[i] = '0;
      end
    endfunction

    // Coin value in cents of a slot
    static function int unsigned cents_of(int slot);
      case (slot)
        0:       return 10;
        1:       return 20;
        2:       return 50;
        3:       return 100;
        4:       return 200;
        5:       return 500;
        6:       return 1000;
        7:       return 2000;
        default: return 5000;
      endcase
    endfunction

    // Clamp an exact count to the counter range
    function logic [31:0] sat_count(longint unsigned x);
      if (x > 64'h0000_0000_FFFF_FFFF) return '1;
      return 32'(x);
    endfunction

    function void add_expected(status_e st, logic [12:0] val, logic [31:0] cnt, logic lst);
      out_item_t r;
      r.status    = st;
      r.out_value = val;
      r.out_count = cnt;
      r.last      = lst;
      due_results.push_back(r);
    endfunction

    // Update the cash model for an accepted item and queue its results
    function void take_command(in_item_t cmd);
      int slot;
      int hi;
      longint unsigned rem, v, avail, units;
      logic [31:0] paid [9];
      slot = -1;
      hi   = -1;
      case (cmd.action)
        ACT_PROVISION, ACT_INSERT: begin
          for (int i = 0; i < 9; i++)
            if (cents_of(i) == cmd.denom_value) slot = i;
          if (slot < 0) begin
            add_expected(ST_BAD_DENOM, '0, '0, 1'b1);
          end else begin
            if (cmd.action == ACT_PROVISION)
              stock[slot] = sat_count(64'(stock[slot]) + 64'(cmd.quantity));
            else
              escrow[slot] = sat_count(64'(escrow[slot]) + 64'(cmd.quantity));
            add_expected(ST_OK, cmd.denom_value[12:0], '0, 1'b1);
          end
        end
        ACT_DISPENSE: begin
          // Greedy walk from the largest coin, stock and escrow both count
          rem = 64'(cmd.amount);
          for (int i = 8; i >= 0; i--) begin
            paid[i] = '0;
            v = cents_of(i);
            if (v <= rem) begin
              avail = 64'(stock[i]) + 64'(escrow[i]);
              units = rem / v;
              if (avail < units) units = avail;
              rem = rem - v * units;
              paid[i] = 32'(units);
            end
          end
          if (rem != 0) begin
            add_expected(ST_NO_CASH, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < 9; i++)
              if (paid[i] != 0) hi = i;
            for (int i = 0; i < 9; i++) begin
              stock[i]  = sat_count(64'(stock[i]) + 64'(escrow[i]) - 64'(paid[i]));
              escrow[i] = '0;
              if (paid[i] != 0)
                add_expected(ST_OK, 13'(cents_of(i)), paid[i], i == hi);
            end
            if (hi < 0) add_expected(ST_OK, '0, '0, 1'b1);
          end
        end
        default: begin
          // Return every escrow count, zeros included
          for (int i = 0; i < 9; i++) begin
            add_expected(ST_OK, 13'(cents_of(i)), escrow[i], i == 8);
            escrow[i] = '0;
          end
        end
      endcase
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      err_cnt++;
      $display("%0t ns: result mismatch on %s: got %0h, wanted %0h", $time, field, got, want);
    endtask

    // Compare an accepted result item with the oldest expected one
    task check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        report("unexpected item", 64'(got), '0);
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status) report("status", 64'(got.status), 64'(want.status));
      if (got.out_value !== want.out_value)
        report("out_value", 64'(got.out_value), 64'(want.out_value));
      if (got.out_count !== want.out_count)
        report("out_count", 64'(got.out_count), 64'(want.out_count));
      if (got.last !== want.last) report("last", 64'(got.last), 64'(want.last));
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  bit        calm = 1'b0;
  int        stall_left = 0;
  int        rest_left = 0;

  cash_scoreboard sb = new();

  change_dispenser_greedy_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #4_000_000;
    $display("change_dispenser_greedy_unit regression: fail");
    $finish;
  end

  // Stall the result channel in short random bursts, with quiet stretches
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm || rest_left > 0) begin
        out_stall <= 1'b0;
        if (rest_left > 0) rest_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 15) == 0) rest_left = $urandom_range(20, 60);
      end
    end
  end

  // Check every result item taken from the block
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  function automatic in_item_t mk_cmd(action_e act, logic [15:0] dval, logic [31:0] qty,
                                      logic [31:0] amt);
    in_item_t c;
    c.action      = act;
    c.denom_value = dval;
    c.quantity    = qty;
    c.amount      = amt;
    return c;
  endfunction

  // Mostly well-formed cash traffic with random content, some noise
  function automatic in_item_t next_command();
    in_item_t c;
    int pick;
    int r;
    c.denom_value = 16'($urandom);
    c.quantity    = $urandom;
    c.amount      = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 25)      c.action = ACT_PROVISION;
    else if (pick < 50) c.action = ACT_INSERT;
    else if (pick < 88) c.action = ACT_DISPENSE;
    else                c.action = ACT_ROLLBACK;
    if (c.action == ACT_PROVISION || c.action == ACT_INSERT) begin
      if ($urandom_range(0, 9) < 8)
        c.denom_value = 16'(cash_scoreboard::cents_of($urandom_range(0, 8)));
      r = $urandom_range(0, 19);
      if (r == 1)      c.quantity = '1;
      else if (r > 1)  c.quantity = $urandom_range(0, 12);
    end else if (c.action == ACT_DISPENSE) begin
      r = $urandom_range(0, 19);
      if (r == 2)      c.amount = $urandom_range(0, 99);
      else if (r > 2)  c.amount = 10 * $urandom_range(0, 1500);
    end
    return c;
  endfunction

  // Offer one item and hold it until the block takes it
  task send_command(in_item_t cmd);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= cmd;
    do @(posedge clk); while (in_stall);
    sb.take_command(cmd);
  endtask

  initial begin
    in_item_t directed [$];
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;

    // Bad coins, empty machine, saturation, greedy dead ends, rollback
    directed.push_back(mk_cmd(ACT_PROVISION, 16'd0, 32'd5, 32'd0));
    directed.push_back(mk_cmd(ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(mk_cmd(ACT_DISPENSE, 16'd0, 32'd0, 32'd0));
    directed.push_back(mk_cmd(ACT_DISPENSE, 16'd0, 32'd0, 32'd10));
    directed.push_back(mk_cmd(ACT_ROLLBACK, 16'd0, 32'd0, 32'd0));
    directed.push_back(mk_cmd(ACT_PROVISION, 16'd10, 32'hFFFF_FFFF, 32'd0));
    directed.push_back(mk_cmd(ACT_PROVISION, 16'd10, 32'd7, 32'd0));
    directed.push_back(mk_cmd(ACT_INSERT, 16'd5000, 32'hFFFF_FFFF, 32'd0));
    directed.push_back(mk_cmd(ACT_INSERT, 16'd5000, 32'd1, 32'd0));
    directed.push_back(mk_cmd(ACT_DISPENSE, 16'd0, 32'd0, 32'hFFFF_FFFF));
    directed.push_back(mk_cmd(ACT_DISPENSE, 16'd0, 32'd0, 32'hFFFF_FFF6));
    directed.push_back(mk_cmd(ACT_PROVISION, 16'd20, 32'hFFFF_FFFF, 32'd0));
    directed.push_back(mk_cmd(ACT_INSERT, 16'd20, 32'd100, 32'd0));
    directed.push_back(mk_cmd(ACT_DISPENSE, 16'd0, 32'd0, 32'd20));
    directed.push_back(mk_cmd(ACT_INSERT, 16'd50, 32'd3, 32'd0));
    directed.push_back(mk_cmd(ACT_INSERT, 16'd100, 32'd0, 32'd0));
    directed.push_back(mk_cmd(ACT_INSERT, 16'd200, 32'd2, 32'd0));
    directed.push_back(mk_cmd(ACT_ROLLBACK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(mk_cmd(ACT_PROVISION, 16'd500, 32'd4, 32'd0));
    directed.push_back(mk_cmd(ACT_PROVISION, 16'd1000, 32'd2, 32'd0));
    directed.push_back(mk_cmd(ACT_INSERT, 16'd2000, 32'd1, 32'd0));
    directed.push_back(mk_cmd(ACT_INSERT, 16'd5001, 32'd1, 32'd0));
    directed.push_back(mk_cmd(ACT_DISPENSE, 16'd0, 32'd0, 32'd15));
    directed.push_back(mk_cmd(ACT_DISPENSE, 16'd0, 32'd0, 32'd3780));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_command(directed[i]);

    // Random traffic, the tail end without idling on either side
    for (int k = 0; k < 330; k++) begin
      if (k == 280) calm = 1'b1;
      send_command(next_command());
    end
    in_valid <= 1'b0;

    // Drain, then allow the block's worst latency for stray items
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);

    if (sb.err_cnt == 0) begin
      $display("change_dispenser_greedy_unit regression: pass");
    end else begin
      $display("change_dispenser_greedy_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/cdg_pkg.sv
hw/rtl/cdg_cnt_mem.sv
hw/rtl/cdg_quot.sv
hw/rtl/change_dispenser_greedy_unit.sv
sim/tb_top.sv
